FILE: rtl/core/bcc_pkg.sv
// Shared types and constants for the button click and hold classifier.
// Used by bcc_classify and button_click_hold_classifier; no dependencies.
`default_nettype none

package bcc_pkg;

  // Event codes carried in the result transfer.
  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_HOLD   = 3'd1,
    EV_CANCEL = 3'd2,
    EV_SILENT = 3'd3,
    EV_TOGGLE = 3'd4
  } bcc_event_t;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [2:0] REG_SHORT_MIN = 3'd0;
  localparam logic [2:0] REG_SHORT_MAX = 3'd1;
  localparam logic [2:0] REG_GAP       = 3'd2;
  localparam logic [2:0] REG_HOLD_MIN  = 3'd3;
  localparam logic [2:0] REG_HOLD_MAX  = 3'd4;
  localparam logic [2:0] REG_SILENT    = 3'd5;
  localparam logic [2:0] REG_TOGGLE    = 3'd6;

  localparam logic [15:0] SHORT_MIN_RST = 16'd60;
  localparam logic [15:0] SHORT_MAX_RST = 16'd400;
  localparam logic [15:0] GAP_RST       = 16'd400;
  localparam logic [15:0] HOLD_MIN_RST  = 16'd1000;
  localparam logic [15:0] HOLD_MAX_RST  = 16'd3000;
  localparam logic [3:0]  SILENT_RST    = 4'd2;
  localparam logic [3:0]  TOGGLE_RST    = 4'd5;

  localparam logic [3:0]  TALLY_MAX     = 4'd15;

  typedef struct packed {
    logic [15:0] short_min_ms;
    logic [15:0] short_max_ms;
    logic [15:0] gap_ms;
    logic [15:0] hold_min_ms;
    logic [15:0] hold_max_ms;
    logic [3:0]  silent_clicks;
    logic [3:0]  toggle_clicks;
  } bcc_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/bcc_classify.sv
// Single-pass classification of one button sample: edge detection, press
// duration tests and click sequence resolution. Depends on bcc_pkg.
`default_nettype none

module bcc_classify
  import bcc_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  var bcc_cfg_t             cfg,
  input  wire logic                level,
  input  wire logic [31:0]         now_ms,
  input  wire logic                prev_level,
  input  wire logic [TIME_BITS-1:0] press_stamp,
  input  wire logic [TIME_BITS-1:0] release_stamp,
  input  wire logic [3:0]          click_tally,
  output logic [TIME_BITS-1:0]     press_stamp_nxt,
  output logic [TIME_BITS-1:0]     release_stamp_nxt,
  output logic [3:0]               click_tally_nxt,
  output bcc_event_t               event_res,
  output logic [3:0]               clicks_seen
);

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] press_dur;
  logic [TIME_BITS-1:0] click_gap;
  logic [TIME_BITS-1:0] end_gap;
  logic [TIME_BITS-1:0] short_min_w;
  logic [TIME_BITS-1:0] short_max_w;
  logic [TIME_BITS-1:0] gap_w;
  logic [TIME_BITS-1:0] hold_min_w;
  logic [TIME_BITS-1:0] hold_max_w;
  logic                 rise;
  logic [3:0]           tally_mid;

  assign now_t       = TIME_BITS'(now_ms);
  assign short_min_w = TIME_BITS'(cfg.short_min_ms);
  assign short_max_w = TIME_BITS'(cfg.short_max_ms);
  assign gap_w       = TIME_BITS'(cfg.gap_ms);
  assign hold_min_w  = TIME_BITS'(cfg.hold_min_ms);
  assign hold_max_w  = TIME_BITS'(cfg.hold_max_ms);

  assign rise      = level & ~prev_level;
  assign press_dur = now_t - press_stamp;
  assign click_gap = now_t - release_stamp;

  assign press_stamp_nxt = (~level & prev_level) ? now_t : press_stamp;

  always_comb begin
    bcc_event_t edge_ev;
    edge_ev           = EV_NONE;
    tally_mid         = click_tally;
    release_stamp_nxt = release_stamp;
    if (rise) begin
      if (press_dur >= hold_min_w && press_dur <= hold_max_w) begin
        edge_ev   = EV_HOLD;
        tally_mid = '0;
      end else if (press_dur > hold_max_w) begin
        edge_ev   = EV_CANCEL;
        tally_mid = '0;
      end else if (press_dur >= short_min_w && press_dur < short_max_w) begin
        if (click_gap < gap_w) begin
          if (click_tally != TALLY_MAX) begin
            tally_mid = click_tally + 4'd1;
          end
        end else begin
          tally_mid = 4'd1;
        end
        release_stamp_nxt = now_t;
      end
    end

    // The end-of-sequence test sees the release time after this sample's edge.
    end_gap         = now_t - release_stamp_nxt;
    event_res       = edge_ev;
    clicks_seen     = '0;
    click_tally_nxt = tally_mid;
    if (tally_mid != 4'd0 && end_gap > gap_w) begin
      if (tally_mid >= cfg.toggle_clicks) begin
        event_res   = EV_TOGGLE;
        clicks_seen = tally_mid;
      end else if (tally_mid == cfg.silent_clicks) begin
        event_res   = EV_SILENT;
        clicks_seen = tally_mid;
      end
      click_tally_nxt = '0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/button_click_hold_classifier.sv
// Top level of the button click and hold classifier: stream ports, APB
// register file, input and result registers. Depends on bcc_pkg, bcc_classify.
`default_nettype none

// One button sample is accepted per clock cycle when the output is not stalled.
// A sample passes through an input register, is classified in one pass
// against the press, release and click-count state, and its event lands in
// the result register. A stalled result holds the pipeline: the input
// register then fills and in_tready drops until out_tready returns. Every
// sample yields exactly one result, event 0 when nothing happened. Time
// differences are taken modulo 2^TIME_BITS. The user must write registers
// through the APB port only while no sample is in flight; the block itself
// does not enforce this.
module button_click_hold_classifier
  import bcc_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,    // [0] level, [32:1] now_ms, [39:33] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,   // [2:0] event_res, [6:3] clicks_seen, [7] zero
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  bcc_cfg_t             cfg_r, cfg_nxt;

  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s1_level_r;
  logic [31:0]          s1_now_r;

  logic                 prev_level_r;
  logic [TIME_BITS-1:0] press_r, release_r;
  logic [3:0]           tally_r;

  logic [TIME_BITS-1:0] press_nxt, release_nxt;
  logic [3:0]           tally_nxt;
  bcc_event_t           event_nxt;
  logic [3:0]           clicks_nxt;

  logic                 out_valid_r;
  bcc_event_t           out_event_r;
  logic [3:0]           out_clicks_r;

  logic                 advance;
  logic                 fire;
  logic                 in_fire;
  logic                 cfg_wr;
  logic [2:0]           cfg_idx;

  assign advance   = ~out_valid_r | out_tready;
  assign fire      = s1_valid_r & advance;
  assign in_tready = ~s1_valid_r | advance;
  assign in_fire   = in_tvalid & in_tready;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // Register file.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_SHORT_MIN: cfg_nxt.short_min_ms  = cfg_pwdata[15:0];
        REG_SHORT_MAX: cfg_nxt.short_max_ms  = cfg_pwdata[15:0];
        REG_GAP:       cfg_nxt.gap_ms        = cfg_pwdata[15:0];
        REG_HOLD_MIN:  cfg_nxt.hold_min_ms   = cfg_pwdata[15:0];
        REG_HOLD_MAX:  cfg_nxt.hold_max_ms   = cfg_pwdata[15:0];
        REG_SILENT:    cfg_nxt.silent_clicks = cfg_pwdata[3:0];
        REG_TOGGLE:    cfg_nxt.toggle_clicks = cfg_pwdata[3:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SHORT_MIN: cfg_prdata = {16'd0, cfg_r.short_min_ms};
      REG_SHORT_MAX: cfg_prdata = {16'd0, cfg_r.short_max_ms};
      REG_GAP:       cfg_prdata = {16'd0, cfg_r.gap_ms};
      REG_HOLD_MIN:  cfg_prdata = {16'd0, cfg_r.hold_min_ms};
      REG_HOLD_MAX:  cfg_prdata = {16'd0, cfg_r.hold_max_ms};
      REG_SILENT:    cfg_prdata = {28'd0, cfg_r.silent_clicks};
      REG_TOGGLE:    cfg_prdata = {28'd0, cfg_r.toggle_clicks};
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_min_ms  <= SHORT_MIN_RST;
      cfg_r.short_max_ms  <= SHORT_MAX_RST;
      cfg_r.gap_ms        <= GAP_RST;
      cfg_r.hold_min_ms   <= HOLD_MIN_RST;
      cfg_r.hold_max_ms   <= HOLD_MAX_RST;
      cfg_r.silent_clicks <= SILENT_RST;
      cfg_r.toggle_clicks <= TOGGLE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Input register.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_level_r <= in_tdata[0];
      s1_now_r   <= in_tdata[32:1];
    end
  end

  bcc_classify #(
    .TIME_BITS (TIME_BITS)
  ) u_classify (
    .cfg               (cfg_r),
    .level             (s1_level_r),
    .now_ms            (s1_now_r),
    .prev_level        (prev_level_r),
    .press_stamp       (press_r),
    .release_stamp     (release_r),
    .click_tally       (tally_r),
    .press_stamp_nxt   (press_nxt),
    .release_stamp_nxt (release_nxt),
    .click_tally_nxt   (tally_nxt),
    .event_res         (event_nxt),
    .clicks_seen       (clicks_nxt)
  );

  // Classifier state moves only when a sample is handed to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 1'b1;
      press_r      <= '0;
      release_r    <= '0;
      tally_r      <= '0;
    end else if (fire) begin
      prev_level_r <= s1_level_r;
      press_r      <= press_nxt;
      release_r    <= release_nxt;
      tally_r      <= tally_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_event_r  <= event_nxt;
      out_clicks_r <= clicks_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_clicks_r, out_event_r};

  a_count_only_on_clicks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_event_r == EV_NONE || out_event_r == EV_HOLD ||
                    out_event_r == EV_CANCEL) |-> out_clicks_r == 4'd0)
    else $error("clicks_seen nonzero on a non-click event");

  a_tally_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (event_nxt == EV_TOGGLE || event_nxt == EV_SILENT ||
             event_nxt == EV_HOLD || event_nxt == EV_CANCEL) |=> tally_r == 4'd0)
    else $error("click tally not cleared after an event");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_tready |-> !in_tready)
    else $error("input accepted while pipeline is full");

  a_result_follows_fire: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r && out_event_r == $past(event_nxt))
    else $error("result register missed a classified sample");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking bench for button_click_hold_classifier: drives button samples over
// the input stream and register settings over APB, and checks every result transfer
// against a cycle-free model of the classifier. Depends on bcc_pkg and the RTL.
module testbench;
  import bcc_pkg::*;

  localparam int unsigned LONG_STALL = 300;
  // The longest correct stall is the LONG_STALL hold-off on the result side, so
  // reaching QUIET_LIMIT with no transfer can only mean a hang.
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [3:0] seen;
    bcc_event_t ev;
  } event_result_t;

  typedef struct packed {
    logic        lvl;
    logic [31:0] t;
    logic        typed;
    bcc_event_t  ev;
    logic [3:0]  seen;
  } sample_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;    // [0] level, [32:1] now_ms, [39:33] zero
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;   // [2:0] event_res, [6:3] clicks_seen, [7] zero
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Copy of the classifier state and registers.
  bcc_cfg_t    cfg = {SHORT_MIN_RST, SHORT_MAX_RST, GAP_RST, HOLD_MIN_RST, HOLD_MAX_RST,
                      SILENT_RST, TOGGLE_RST};
  logic        btn_level_q = 1'b1;
  logic [31:0] press_at = '0;
  logic [31:0] release_at = '0;
  logic [3:0]  click_count = '0;

  event_result_t pending_events [$];
  event_result_t want;
  logic [31:0]   clock_ms;
  int unsigned   samples_sent;
  int unsigned   results_checked;
  int unsigned   mismatches;
  int unsigned   quiet_cycles;
  int unsigned   kinds_seen [8];
  int unsigned   send_idle_pct;
  int unsigned   recv_stall_pct;
  bit            long_stall_req;

  // Hand-written sequence at reset settings: hold limits, cancel, a double click
  // with the gap boundary, the short-press ceiling and timestamps across the wrap.
  sample_row_t directed_rows [21] = '{
    {1'b1, 32'd0,          1'b1, EV_NONE,   4'd0},
    {1'b0, 32'd100,        1'b0, EV_NONE,   4'd0},
    {1'b0, 32'd150,        1'b0, EV_NONE,   4'd0},
    {1'b1, 32'd1100,       1'b1, EV_HOLD,   4'd0},
    {1'b0, 32'd2000,       1'b0, EV_NONE,   4'd0},
    {1'b1, 32'd5000,       1'b1, EV_HOLD,   4'd0},
    {1'b0, 32'd6000,       1'b0, EV_NONE,   4'd0},
    {1'b1, 32'd9001,       1'b1, EV_CANCEL, 4'd0},
    {1'b0, 32'd10000,      1'b0, EV_NONE,   4'd0},
    {1'b1, 32'd10060,      1'b0, EV_NONE,   4'd0},
    {1'b0, 32'd10200,      1'b0, EV_NONE,   4'd0},
    {1'b1, 32'd10300,      1'b0, EV_NONE,   4'd0},
    {1'b1, 32'd10700,      1'b0, EV_NONE,   4'd0},
    {1'b1, 32'd10701,      1'b1, EV_SILENT, 4'd2},
    {1'b0, 32'd11000,      1'b0, EV_NONE,   4'd0},
    {1'b1, 32'd11400,      1'b1, EV_NONE,   4'd0},
    {1'b0, 32'hFFFF_FFF0,  1'b0, EV_NONE,   4'd0},
    {1'b1, 32'h0000_0050,  1'b0, EV_NONE,   4'd0},
    {1'b1, 32'h0000_01E1,  1'b1, EV_NONE,   4'd0},
    {1'b0, 32'hFFFF_FFFF,  1'b0, EV_NONE,   4'd0},
    {1'b1, 32'h0000_0000,  1'b1, EV_NONE,   4'd0}
  };

  button_click_hold_classifier u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  function automatic void classify_sample(input logic lvl, input logic [31:0] t,
                                          output event_result_t res);
    logic [31:0] held;
    logic [31:0] since_release;
    res = 7'd0;
    held = t - press_at;
    if (!lvl && btn_level_q) press_at = t;
    if (lvl && !btn_level_q) begin
      since_release = t - release_at;
      if (held >= cfg.hold_min_ms && held <= cfg.hold_max_ms) begin
        res.ev = EV_HOLD;
        click_count = '0;
      end else if (held > cfg.hold_max_ms) begin
        res.ev = EV_CANCEL;
        click_count = '0;
      end else if (held >= cfg.short_min_ms && held < cfg.short_max_ms) begin
        // A click inside the gap extends the run; a late one starts a new run.
        if (since_release < cfg.gap_ms) begin
          if (click_count != TALLY_MAX) click_count = click_count + 4'd1;
        end else begin
          click_count = 4'd1;
        end
        release_at = t;
      end
    end
    since_release = t - release_at;
    if (click_count != 4'd0 && since_release > cfg.gap_ms) begin
      if (click_count >= cfg.toggle_clicks) begin
        res.ev = EV_TOGGLE;
        res.seen = click_count;
      end else if (click_count == cfg.silent_clicks) begin
        res.ev = EV_SILENT;
        res.seen = click_count;
      end
      click_count = '0;
    end
    btn_level_q = lvl;
  endfunction

  function automatic int unsigned pick_span(input int unsigned lo, input int unsigned hi);
    if (hi <= lo) return lo;
    case ($urandom_range(3, 0))
      0: return lo;
      1: return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  // Offers one sample and, once the transfer happens, records what it must produce.
  task automatic send_sample(input logic lvl, input logic [31:0] t, input logic typed,
                             input event_result_t typed_res);
    event_result_t res;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, t, lvl};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    classify_sample(lvl, t, res);
    pending_events.push_back(typed ? typed_res : res);
    samples_sent++;
  endtask

  task automatic tick(input logic lvl, input int unsigned dt);
    clock_ms = clock_ms + dt;
    send_sample(lvl, clock_ms, 1'b0, 7'd0);
  endtask

  task automatic await_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_SHORT_MIN: cfg.short_min_ms = value[15:0];
      REG_SHORT_MAX: cfg.short_max_ms = value[15:0];
      REG_GAP:       cfg.gap_ms = value[15:0];
      REG_HOLD_MIN:  cfg.hold_min_ms = value[15:0];
      REG_HOLD_MAX:  cfg.hold_max_ms = value[15:0];
      REG_SILENT:    cfg.silent_clicks = value[3:0];
      REG_TOGGLE:    cfg.toggle_clicks = value[3:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [15:0] smin, input logic [15:0] smax,
                             input logic [15:0] gap, input logic [15:0] hmin,
                             input logic [15:0] hmax, input logic [3:0] sil,
                             input logic [3:0] tog);
    await_results();
    write_reg(REG_SHORT_MIN, {16'd0, smin});
    write_reg(REG_SHORT_MAX, {16'd0, smax});
    write_reg(REG_GAP,       {16'd0, gap});
    write_reg(REG_HOLD_MIN,  {16'd0, hmin});
    write_reg(REG_HOLD_MAX,  {16'd0, hmax});
    write_reg(REG_SILENT,    {28'd0, sil});
    write_reg(REG_TOGGLE,    {28'd0, tog});
    // Nothing lives at this address, so the write must change nothing.
    write_reg(REG_UNUSED,    $urandom());
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic click_burst();
    int unsigned n;
    int unsigned top;
    n = ($urandom_range(3, 0) == 0) ? $urandom_range(17, 6) : $urandom_range(5, 1);
    top = (cfg.short_max_ms == 0) ? 0 : cfg.short_max_ms - 1;
    if (top > cfg.short_min_ms + cfg.gap_ms / 2) top = cfg.short_min_ms + cfg.gap_ms / 2;
    for (int k = 0; k < n; k++) begin
      if (k == 0) tick(1'b0, $urandom_range(3000, 1));
      else if ($urandom_range(7, 0) == 0) tick(1'b0, $urandom_range(cfg.gap_ms, 0));
      else tick(1'b0, $urandom_range(cfg.gap_ms / 4, 0));
      // Contact bounce shows up as a second pressed sample.
      if ($urandom_range(7, 0) == 0) tick(1'b0, $urandom_range(cfg.short_min_ms, 0));
      tick(1'b1, pick_span(32'(cfg.short_min_ms), top));
    end
    tick(1'b1, 32'(cfg.gap_ms));
    tick(1'b1, 1);
  endtask

  task automatic long_press();
    tick(1'b0, $urandom_range(5000, 1));
    if ($urandom_range(1, 0) != 0) begin
      tick(1'b1, pick_span(32'(cfg.hold_min_ms), 32'(cfg.hold_max_ms)));
    end else begin
      tick(1'b1, cfg.hold_max_ms + pick_span(1, 70000));
    end
  endtask

  task automatic run_phase(input int unsigned count);
    int unsigned stop_at;
    stop_at = samples_sent + count;
    while (samples_sent < stop_at) begin
      case ($urandom_range(9, 0))
        0, 1, 2, 3, 4: click_burst();
        5, 6, 7: long_press();
        default: tick(1'($urandom_range(1, 0)),
                      ($urandom_range(15, 0) == 0) ? $urandom() : $urandom_range(2000, 0));
      endcase
    end
  endtask

  // Result side: ready pattern per phase, plus one long hold-off on request.
  initial begin
    bit stall_done;
    stall_done = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall_req && !stall_done) begin
        stall_done = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end
      out_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      if (pending_events.size() == 0) begin
        $error("result transfer with no sample awaiting it: out_tdata %h", out_tdata);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        kinds_seen[want.ev]++;
        if (out_tdata[2:0] !== want.ev) begin
          $error("event_res: expected %0d, got %0d", want.ev, out_tdata[2:0]);
          mismatches++;
        end
        if (out_tdata[6:3] !== want.seen) begin
          $error("clicks_seen: expected %0d, got %0d", want.seen, out_tdata[6:3]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sample_row_t row;
    int unsigned smin;
    int unsigned smax;
    int unsigned hmin;
    int unsigned hmax;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 21; i++) begin
      row = directed_rows[i];
      send_sample(row.lvl, row.t, row.typed, {row.seen, row.ev});
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0, 7: load_config(SHORT_MIN_RST, SHORT_MAX_RST, GAP_RST, HOLD_MIN_RST,
                          HOLD_MAX_RST, SILENT_RST, TOGGLE_RST);
        2: load_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 4'd0, 4'd0);
        3: load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 4'hF);
        // Wide short window and gap, so long bursts run the count into saturation.
        4: load_config(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 4'hF);
        // Hold window inside the short window: the hold tests must win.
        6: load_config(16'd0, 16'd5000, 16'd800, 16'd100, 16'd200, 4'd0, 4'd15);
        default: begin
          smin = $urandom_range(150, 0);
          smax = smin + $urandom_range(400, 1);
          hmin = smax + $urandom_range(1500, 0);
          hmax = hmin + $urandom_range(4000, 0);
          load_config(16'(smin), 16'(smax), 16'($urandom_range(700, 20)), 16'(hmin),
                      16'(hmax), 4'($urandom_range(6, 1)), 4'($urandom_range(8, 1)));
        end
      endcase
      send_idle_pct  = (ph % 4 == 1) ? 50 : (ph % 4 == 3) ? 32 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 50 : (ph % 4 == 3) ? 32 : 0;
      clock_ms = ($urandom_range(1, 0) != 0) ? $urandom()
                                             : 32'hFFFF_FFFF - $urandom_range(20000, 0);
      if (ph == 0) long_stall_req = 1'b1;
      if (ph == 1) begin
        run_phase(55);
        await_results();
        run_phase(55);
      end else begin
        run_phase(110);
      end
    end

    await_results();
    repeat (8) @(posedge clk);
    $display("Checked %0d results for %0d samples over eight register settings",
             results_checked, samples_sent);
    $display("and four idle patterns. Events: %0d hold, %0d cancel, %0d silent, %0d toggle.",
             kinds_seen[EV_HOLD], kinds_seen[EV_CANCEL], kinds_seen[EV_SILENT],
             kinds_seen[EV_TOGGLE]);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
